FILE: rtl/pit_pkg.sv
// ============================================================================
// pit_pkg
// Shared types, widths and codes for the point-in-tetrahedron block.
// ============================================================================
`default_nettype none

package pit_pkg;

   // coordinate width and the exact widths of the determinant terms
   localparam int COORD_BITS = 21;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int MINOR_W    = PROD_W + 1;
   localparam int TERM_W     = DIFF_W + MINOR_W;
   localparam int SUM_W      = TERM_W + 2;

   // stream and register widths
   localparam int VERTEX_W   = 63;
   localparam int REQ_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_A = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_B = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_C = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_D = 3'd3;

   // result region codes
   typedef enum logic [1:0] {
      REGION_INSIDE   = 2'd0,
      REGION_BOUNDARY = 2'd1,
      REGION_OUTSIDE  = 2'd2
   } pit_region_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } pit_point_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] z;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] x;
   } pit_diff_type;

   // per-stage load enables of a volume lane
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pit_adv_type;

   // sign of one determinant
   typedef struct packed {
      logic neg;
      logic zero;
   } pit_sign_type;

   // pull x y z out of a vertex register, x in the lowest bits
   function automatic pit_point_type pit_unpack(input logic [VERTEX_W-1:0] v);
      pit_point_type p;
      p.x = v[COORD_BITS-1:0];
      p.y = v[2*COORD_BITS-1:COORD_BITS];
      p.z = v[3*COORD_BITS-1:2*COORD_BITS];
      return p;
   endfunction

   // exact difference a - b
   function automatic pit_diff_type pit_sub(input pit_point_type a, input pit_point_type b);
      pit_diff_type d;
      d.x = DIFF_W'(a.x) - DIFF_W'(b.x);
      d.y = DIFF_W'(a.y) - DIFF_W'(b.y);
      d.z = DIFF_W'(a.z) - DIFF_W'(b.z);
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pit_vol_lane.sv
// ============================================================================
// pit_vol_lane
// Five-stage pipeline giving the exact sign of det(r-p, s-p, t-p).
// ============================================================================
`default_nettype none

module pit_vol_lane import pit_pkg::*; (
   input  logic          clock,
   input  pit_adv_type   adv,
   input  pit_point_type p_pt,
   input  pit_point_type r_pt,
   input  pit_point_type s_pt,
   input  pit_point_type t_pt,
   output pit_sign_type  sign
);

   pit_diff_type u_in, v_in, w_in;
   pit_diff_type u_ff, v_ff, w_ff;
   pit_diff_type u2_ff, u3_ff;

   logic signed [PROD_W-1:0]  prod_in  [6];
   logic signed [PROD_W-1:0]  prod_ff  [6];
   logic signed [MINOR_W-1:0] minor_in [3];
   logic signed [MINOR_W-1:0] minor_ff [3];
   logic signed [TERM_W-1:0]  term_in  [3];
   logic signed [TERM_W-1:0]  term_ff  [3];
   logic signed [SUM_W-1:0]   sum_in;
   pit_sign_type              sign_in;
   pit_sign_type              sign_ff;

   // stage 1: edge vectors
   always_comb begin
      u_in = pit_sub(r_pt, p_pt);
      v_in = pit_sub(s_pt, p_pt);
      w_in = pit_sub(t_pt, p_pt);
   end

   // stage 2: cross-product partial products
   always_comb begin
      prod_in[0] = PROD_W'(v_ff.y) * PROD_W'(w_ff.z);
      prod_in[1] = PROD_W'(v_ff.z) * PROD_W'(w_ff.y);
      prod_in[2] = PROD_W'(v_ff.z) * PROD_W'(w_ff.x);
      prod_in[3] = PROD_W'(v_ff.x) * PROD_W'(w_ff.z);
      prod_in[4] = PROD_W'(v_ff.x) * PROD_W'(w_ff.y);
      prod_in[5] = PROD_W'(v_ff.y) * PROD_W'(w_ff.x);
   end

   // stage 3: cross-product components
   always_comb begin
      minor_in[0] = MINOR_W'(prod_ff[0]) - MINOR_W'(prod_ff[1]);
      minor_in[1] = MINOR_W'(prod_ff[2]) - MINOR_W'(prod_ff[3]);
      minor_in[2] = MINOR_W'(prod_ff[4]) - MINOR_W'(prod_ff[5]);
   end

   // stage 4: dot-product terms
   always_comb begin
      term_in[0] = TERM_W'(u3_ff.x) * TERM_W'(minor_ff[0]);
      term_in[1] = TERM_W'(u3_ff.y) * TERM_W'(minor_ff[1]);
      term_in[2] = TERM_W'(u3_ff.z) * TERM_W'(minor_ff[2]);
   end

   // stage 5: sum and sign
   always_comb begin
      sum_in       = SUM_W'(term_ff[0]) + SUM_W'(term_ff[1]) + SUM_W'(term_ff[2]);
      sign_in.neg  = sum_in[SUM_W-1];
      sign_in.zero = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         u_ff <= u_in;
         v_ff <= v_in;
         w_ff <= w_in;
      end
      if (adv.s2) begin
         prod_ff <= prod_in;
         u2_ff   <= u_ff;
      end
      if (adv.s3) begin
         minor_ff <= minor_in;
         u3_ff    <= u2_ff;
      end
      if (adv.s4) begin
         term_ff <= term_in;
      end
      if (adv.s5) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

`default_nettype wire

FILE: rtl/point_in_tetrahedron_top.sv
// ============================================================================
// point_in_tetrahedron_top
// Classifies query points against a tetrahedron held in vertex registers.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  req_      in         req_tvalid / req_tready   query x, y, z
//  rsp_      out        rsp_tvalid / rsp_tready   region, degenerate, face masks
//  csr_      in         csr_valid / csr_ready     csr_addr, csr_wdata (vertex a..d)
//
//  One item per cycle unless the output stalls; five stages in each volume lane
//  (edges, products, minors, dot terms, sum/sign) plus the result register.
//  Reset clears all stage valid bits and the vertex registers to zero.
//  Each stage loads when it is empty or the next one moves, so bubbles are
//  squeezed out during a stall and the pipe keeps filling until it is full.
//  csr_ready is always high.
// ============================================================================
`default_nettype none

module point_in_tetrahedron_top import pit_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // query_x, query_y, query_z from bit 0 up, zero padded
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // region[1:0], degenerate, positive_faces[3:0], negative_faces[3:0], zero padded
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [VERTEX_W-1:0]   csr_wdata
);

   logic [VERTEX_W-1:0] vtx_a_ff, vtx_b_ff, vtx_c_ff, vtx_d_ff;
   pit_point_type       pa, pb, pc, pd, pq;
   logic [4:0]          vld_ff;
   logic [5:0]          rdy;
   pit_adv_type         adv;
   pit_sign_type        sgn [5];

   logic                rsp_tvalid_ff;
   pit_region_type      region_ff, region_in;
   logic                degen_ff, degen_in;
   logic [3:0]          pos_ff, pos_in;
   logic [3:0]          neg_ff, neg_in;

   // vertex registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vtx_a_ff <= '0;
         vtx_b_ff <= '0;
         vtx_c_ff <= '0;
         vtx_d_ff <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_VERTEX_A: vtx_a_ff <= csr_wdata;
            CSR_VERTEX_B: vtx_b_ff <= csr_wdata;
            CSR_VERTEX_C: vtx_c_ff <= csr_wdata;
            CSR_VERTEX_D: vtx_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pa   = pit_unpack(vtx_a_ff);
      pb   = pit_unpack(vtx_b_ff);
      pc   = pit_unpack(vtx_c_ff);
      pd   = pit_unpack(vtx_d_ff);
      pq.x = req_tdata[COORD_BITS-1:0];
      pq.y = req_tdata[2*COORD_BITS-1:COORD_BITS];
      pq.z = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   end

   // per-stage ready chain, output register last
   always_comb begin
      rdy[5] = !rsp_tvalid_ff || rsp_tready;
      for (int k = 4; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      adv.s1 = rdy[0];
      adv.s2 = rdy[1];
      adv.s3 = rdy[2];
      adv.s4 = rdy[3];
      adv.s5 = rdy[4];
   end

   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rdy[0]) vld_ff[0] <= req_tvalid;
         for (int k = 1; k < 5; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
         if (rdy[5]) rsp_tvalid_ff <= vld_ff[4];
      end
   end

   // lane 0 is the tetrahedron volume, lanes 1..4 replace one vertex by q
   pit_vol_lane u_lane_v (.clock(clock), .adv(adv),
      .p_pt(pa), .r_pt(pb), .s_pt(pc), .t_pt(pd), .sign(sgn[0]));
   pit_vol_lane u_lane_1 (.clock(clock), .adv(adv),
      .p_pt(pq), .r_pt(pb), .s_pt(pc), .t_pt(pd), .sign(sgn[1]));
   pit_vol_lane u_lane_2 (.clock(clock), .adv(adv),
      .p_pt(pa), .r_pt(pq), .s_pt(pc), .t_pt(pd), .sign(sgn[2]));
   pit_vol_lane u_lane_3 (.clock(clock), .adv(adv),
      .p_pt(pa), .r_pt(pb), .s_pt(pq), .t_pt(pd), .sign(sgn[3]));
   pit_vol_lane u_lane_4 (.clock(clock), .adv(adv),
      .p_pt(pa), .r_pt(pb), .s_pt(pc), .t_pt(pq), .sign(sgn[4]));

   // classification: coordinate sign is the sub-volume sign times the volume sign
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pos_in[i] = !sgn[i+1].zero && (sgn[i+1].neg == sgn[0].neg);
         neg_in[i] = !sgn[i+1].zero && (sgn[i+1].neg != sgn[0].neg);
      end
      degen_in = sgn[0].zero;
      if (sgn[0].zero) begin
         pos_in    = '0;
         neg_in    = '0;
         region_in = REGION_BOUNDARY;
      end else if (neg_in != '0) begin
         region_in = REGION_OUTSIDE;
      end else if (pos_in == 4'hF) begin
         region_in = REGION_INSIDE;
      end else begin
         region_in = REGION_BOUNDARY;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         region_ff <= region_in;
         degen_ff  <= degen_in;
         pos_ff    <= pos_in;
         neg_ff    <= neg_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, neg_ff, pos_ff, degen_ff, region_ff};

   // checks
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff && rsp_tvalid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline full and stalled");

   a_degen_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && degen_ff) |->
         (region_ff == REGION_BOUNDARY && pos_ff == 4'h0 && neg_ff == 4'h0))
      else $error("degenerate result with nonzero face masks");

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> ((pos_ff & neg_ff) == 4'h0))
      else $error("face positive and negative at once");

   a_inside_all: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && region_ff == REGION_INSIDE) |-> (pos_ff == 4'hF))
      else $error("inside without all faces positive");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ============================================================================
// tb
// Self-checking bench for the point-in-tetrahedron classifier: loads vertex
// sets over the register port, streams query points through the request
// channel and checks every result against an exact determinant predictor.
// ============================================================================
`default_nettype none

module tb import pit_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX = 2 ** (COORD_BITS - 1) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   // result bit positions inside rsp_tdata
   localparam int DEGEN_BIT = 2;
   localparam int POS_LSB   = 3;
   localparam int NEG_LSB   = 7;

   typedef logic signed [127:0] det_type;

   typedef struct {
      pit_region_type region;
      logic           degenerate;
      logic [3:0]     pos_faces;
      logic [3:0]     neg_faces;
   } verdict_type;

   typedef enum {
      SHAPE_TINY,
      SHAPE_MEDIUM,
      SHAPE_WIDE,
      SHAPE_CORNERS,
      SHAPE_FLAT
   } tetra_shape_type;

   typedef enum {
      READY_ALWAYS,
      READY_RANDOM,
      READY_ONE_IN_FOUR,
      READY_BURSTY
   } ready_pattern_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [VERTEX_W-1:0]   csr_wdata  = '0;

   // shadow of the vertex registers
   logic [VERTEX_W-1:0] vertex_regs [4] = '{default: '0};

   pit_point_type query_q [$];
   verdict_type   verdict_q [$];
   verdict_type   want;
   int            mismatches = 0;

   // sender burst/gap and receiver stall bookkeeping
   int                burst_left = 0;
   int                gap_left   = 0;
   ready_pattern_type ready_mode = READY_ALWAYS;
   int                mode_left  = 0;
   int                cycle_n    = 0;

   point_in_tetrahedron_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // exact classification
   // --------------------------------------------------------------------------
   function automatic longint sx(logic [COORD_BITS-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic pit_point_type mk_point(longint x, longint y, longint z);
      pit_point_type p;
      p.x = COORD_BITS'(clamp_coord(x));
      p.y = COORD_BITS'(clamp_coord(y));
      p.z = COORD_BITS'(clamp_coord(z));
      return p;
   endfunction

   // sign of det(r-p, s-p, t-p), kept exact in 128 bits
   function automatic int volume_sign(pit_point_type p, pit_point_type r,
                                      pit_point_type s, pit_point_type t);
      longint  ux, uy, uz, vx, vy, vz, wx, wy, wz, m1, m2, m3;
      det_type acc, f1, f2;
      ux = sx(r.x) - sx(p.x);
      uy = sx(r.y) - sx(p.y);
      uz = sx(r.z) - sx(p.z);
      vx = sx(s.x) - sx(p.x);
      vy = sx(s.y) - sx(p.y);
      vz = sx(s.z) - sx(p.z);
      wx = sx(t.x) - sx(p.x);
      wy = sx(t.y) - sx(p.y);
      wz = sx(t.z) - sx(p.z);
      m1 = vy * wz - vz * wy;
      m2 = vz * wx - vx * wz;
      m3 = vx * wy - vy * wx;
      f1 = ux; f2 = m1; acc = f1 * f2;
      f1 = uy; f2 = m2; acc = acc + f1 * f2;
      f1 = uz; f2 = m3; acc = acc + f1 * f2;
      if (acc < 0) return -1;
      return (acc == 0) ? 0 : 1;
   endfunction

   function automatic verdict_type classify_point(pit_point_type q);
      pit_point_type a, b, c, d;
      int            vol, s [4];
      verdict_type   v;
      a = pit_point_type'(vertex_regs[CSR_VERTEX_A]);
      b = pit_point_type'(vertex_regs[CSR_VERTEX_B]);
      c = pit_point_type'(vertex_regs[CSR_VERTEX_C]);
      d = pit_point_type'(vertex_regs[CSR_VERTEX_D]);
      v.region     = REGION_BOUNDARY;
      v.degenerate = 1'b1;
      v.pos_faces  = '0;
      v.neg_faces  = '0;
      vol = volume_sign(a, b, c, d);
      if (vol == 0) return v;
      v.degenerate = 1'b0;
      s[0] = volume_sign(q, b, c, d);
      s[1] = volume_sign(a, q, c, d);
      s[2] = volume_sign(a, b, q, d);
      s[3] = volume_sign(a, b, c, q);
      for (int i = 0; i < 4; i++) begin
         if (s[i] * vol > 0) v.pos_faces[i] = 1'b1;
         else if (s[i] * vol < 0) v.neg_faces[i] = 1'b1;
      end
      if (v.neg_faces != 0) v.region = REGION_OUTSIDE;
      else if (v.pos_faces == 4'hF) v.region = REGION_INSIDE;
      return v;
   endfunction

   // --------------------------------------------------------------------------
   // random geometry
   // --------------------------------------------------------------------------
   function automatic longint rnd(longint lim);
      return longint'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic longint rand_coord();
      return sx(COORD_BITS'($urandom));
   endfunction

   // query points aimed at vertices, edges, faces and the interior
   function automatic pit_point_type pick_query();
      pit_point_type c [4];
      longint        r;
      int            i, j, k;
      for (int n = 0; n < 4; n++) c[n] = pit_point_type'(vertex_regs[n]);
      i = $urandom_range(0, 3);
      j = $urandom_range(0, 3);
      k = $urandom_range(0, 3);
      r = longint'(1) << $urandom_range(0, 12);
      r = $urandom_range(0, 1) ? longint'($urandom_range(0, 3)) : r;
      case ($urandom_range(0, 9))
         0, 1, 2: return mk_point(sx(c[i].x) + rnd(r), sx(c[i].y) + rnd(r),
                                  sx(c[i].z) + rnd(r));
         3: return c[i];
         4: return mk_point((sx(c[i].x) + sx(c[j].x)) / 2,
                            (sx(c[i].y) + sx(c[j].y)) / 2,
                            (sx(c[i].z) + sx(c[j].z)) / 2);
         5: return mk_point((sx(c[i].x) + sx(c[j].x) + sx(c[k].x)) / 3,
                            (sx(c[i].y) + sx(c[j].y) + sx(c[k].y)) / 3,
                            (sx(c[i].z) + sx(c[j].z) + sx(c[k].z)) / 3);
         6, 7: return mk_point(
               (sx(c[0].x) + sx(c[1].x) + sx(c[2].x) + sx(c[3].x)) / 4 + rnd(r),
               (sx(c[0].y) + sx(c[1].y) + sx(c[2].y) + sx(c[3].y)) / 4 + rnd(r),
               (sx(c[0].z) + sx(c[1].z) + sx(c[2].z) + sx(c[3].z)) / 4 + rnd(r));
         default: return mk_point(rand_coord(), rand_coord(), rand_coord());
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // request driver: bursts with random gaps, prediction on acceptance
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            verdict_q.push_back(classify_point(
               pit_point_type'(req_tdata[3*COORD_BITS-1:0])));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (query_q.size() > 0) begin
               req_tdata  <= REQ_DATA_W'(query_q.pop_front());
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                           : $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // result monitor and receiver stall pattern
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual 0x%h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[1:0] !== want.region) begin
                  $display("%0t: region: expected %0d, actual %0d",
                           $time, want.region, rsp_tdata[1:0]);
                  mismatches++;
               end
               if (rsp_tdata[DEGEN_BIT] !== want.degenerate) begin
                  $display("%0t: degenerate: expected %0d, actual %0d",
                           $time, want.degenerate, rsp_tdata[DEGEN_BIT]);
                  mismatches++;
               end
               if (rsp_tdata[POS_LSB +: 4] !== want.pos_faces) begin
                  $display("%0t: positive_faces: expected %b, actual %b",
                           $time, want.pos_faces, rsp_tdata[POS_LSB +: 4]);
                  mismatches++;
               end
               if (rsp_tdata[NEG_LSB +: 4] !== want.neg_faces) begin
                  $display("%0t: negative_faces: expected %b, actual %b",
                           $time, want.neg_faces, rsp_tdata[NEG_LSB +: 4]);
                  mismatches++;
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_pattern_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         cycle_n++;
         case (ready_mode)
            READY_ALWAYS:      rsp_tready <= 1'b1;
            READY_RANDOM:      rsp_tready <= 1'($urandom_range(0, 1));
            READY_ONE_IN_FOUR: rsp_tready <= (cycle_n % 4 == 0);
            default:           rsp_tready <= (cycle_n % 32 >= 20);
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [VERTEX_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (addr <= CSR_VERTEX_D) vertex_regs[addr] = data;
   endtask

   task automatic set_tetra(input pit_point_type a, input pit_point_type b,
                            input pit_point_type c, input pit_point_type d);
      csr_write(CSR_VERTEX_A, a);
      csr_write(CSR_VERTEX_B, b);
      csr_write(CSR_VERTEX_C, c);
      csr_write(CSR_VERTEX_D, d);
   endtask

   task automatic load_tetra(input tetra_shape_type shape);
      pit_point_type v [4];
      longint        lim;
      lim = (shape == SHAPE_TINY) ? longint'($urandom_range(1, 6))
                                  : longint'($urandom_range(50, 5000));
      for (int i = 0; i < 4; i++) begin
         case (shape)
            SHAPE_WIDE:    v[i] = pit_point_type'(VERTEX_W'({$urandom, $urandom}));
            SHAPE_CORNERS: v[i] = mk_point($urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                                           $urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                                           $urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
            default:       v[i] = mk_point(rnd(lim), rnd(lim), rnd(lim));
         endcase
      end
      // zero volume: fourth vertex on the plane of the others, or a repeat
      if (shape == SHAPE_FLAT) begin
         if ($urandom_range(0, 1))
            v[3] = mk_point(sx(v[1].x) + sx(v[2].x) - sx(v[0].x),
                            sx(v[1].y) + sx(v[2].y) - sx(v[0].y),
                            sx(v[1].z) + sx(v[2].z) - sx(v[0].z));
         else
            v[3] = v[$urandom_range(0, 2)];
      end
      set_tetra(v[0], v[1], v[2], v[3]);
   endtask

   // hold off until every request is accepted and answered
   task automatic drain_results();
      do @(negedge clock);
      while (query_q.size() != 0 || req_tvalid || verdict_q.size() != 0);
   endtask

   task automatic queue_point(input longint x, input longint y, input longint z);
      query_q.push_back(mk_point(x, y, z));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (reset);

      // registers at reset value: every point sees a flat tetrahedron
      queue_point(0, 0, 0);
      queue_point(COORD_MAX, COORD_MIN, COORD_MAX);
      drain_results();

      // right-angle corner tetrahedron, positive volume
      set_tetra(mk_point(0, 0, 0), mk_point(1000, 0, 0),
                mk_point(0, 1000, 0), mk_point(0, 0, 1000));
      queue_point(100, 100, 100);
      queue_point(0, 0, 0);
      queue_point(500, 500, 0);
      queue_point(0, 200, 300);
      queue_point(400, 400, 400);
      queue_point(-1, 10, 10);
      queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
      queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
      queue_point(COORD_MAX, COORD_MIN, 0);
      drain_results();

      // writes past the last vertex index must not land anywhere
      for (int i = CSR_VERTEX_D + 1; i < 2 ** CSR_ADDR_W; i++)
         csr_write(CSR_ADDR_W'(i), VERTEX_W'({$urandom, $urandom}));

      // same corner with b and c swapped: negative volume
      csr_write(CSR_VERTEX_B, mk_point(0, 1000, 0));
      csr_write(CSR_VERTEX_C, mk_point(1000, 0, 0));
      queue_point(100, 100, 100);
      queue_point(0, 0, 1000);
      queue_point(-5, 5, 5);
      drain_results();

      // full-range tetrahedron stressing the determinant width
      set_tetra(mk_point(COORD_MIN, COORD_MIN, COORD_MIN),
                mk_point(COORD_MAX, COORD_MIN, COORD_MIN),
                mk_point(COORD_MIN, COORD_MAX, COORD_MIN),
                mk_point(COORD_MIN, COORD_MIN, COORD_MAX));
      queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
      queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
      queue_point(-524288, -524288, -524288);
      queue_point(0, 0, 0);
      queue_point(COORD_MAX, COORD_MAX, COORD_MIN);
      drain_results();

      // coplanar vertices, nonzero coordinates
      set_tetra(mk_point(0, 0, 0), mk_point(10, 0, 0),
                mk_point(0, 10, 0), mk_point(7, 3, 0));
      queue_point(1, 1, 0);
      queue_point(1, 1, 1);
      drain_results();

      // random phases: new vertex set, stray writes, mid-phase full drain
      for (int phase = 0; phase < 12; phase++) begin
         load_tetra(phase < 5 ? tetra_shape_type'(phase)
                              : tetra_shape_type'($urandom_range(0, 4)));
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_ADDR_W'($urandom_range(CSR_VERTEX_D + 1, 2 ** CSR_ADDR_W - 1)),
                      VERTEX_W'({$urandom, $urandom}));
         for (int n = 0; n < 100; n++) begin
            query_q.push_back(pick_query());
            if (n == 50 && phase % 3 == 0) drain_results();
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS point_in_tetrahedron_top");
      else
         $display("FAIL point_in_tetrahedron_top");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("FAIL point_in_tetrahedron_top");
      $finish;
   end

endmodule

`default_nettype wire
